>>> rtl/rgclt_pkg.sv
// Shared widths, command codes and register indexes of the crossing lap timer.
`timescale 1ns / 1ps

package rgclt_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned WAIT_W  = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MINMS_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MS    = 2'd2;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 8'd100;
  localparam logic [MINMS_W-1:0] MIN_MS_RST    = 16'd100;

  // ADC to level scaling shift
  localparam int unsigned ADC_SHIFT = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Result word
  typedef struct packed {
    logic [LEVEL_W-1:0] filtered_level;
    logic               crossing_on;
    logic               crossing_changed;
    logic               lap_valid;
    logic [TIME_W-1:0]  lap_stamp;
    logic [TIME_W-1:0]  lap_duration;
    logic [LEVEL_W-1:0] lap_peak;
    logic [TOTAL_W-1:0] lap_total;
    logic [WAIT_W-1:0]  laps_waiting;
    logic [LEVEL_W-1:0] current_peak;
  } res_word_t;

endpackage

>>> rtl/rgclt_ifs.sv
// Valid/ready channels for command words and result words.
`timescale 1ns / 1ps

interface rgclt_cmd_if import rgclt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ADC_W-1:0]   adc_sample;
  logic [TIME_W-1:0]  time_ms;

  modport source (output valid, command, adc_sample, time_ms, input ready);
  modport sink   (input valid, command, adc_sample, time_ms, output ready);
endinterface

interface rgclt_res_if import rgclt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] filtered_level;
  logic               crossing_on;
  logic               crossing_changed;
  logic               lap_valid;
  logic [TIME_W-1:0]  lap_stamp;
  logic [TIME_W-1:0]  lap_duration;
  logic [LEVEL_W-1:0] lap_peak;
  logic [TOTAL_W-1:0] lap_total;
  logic [WAIT_W-1:0]  laps_waiting;
  logic [LEVEL_W-1:0] current_peak;

  modport source (output valid, filtered_level, crossing_on, crossing_changed, lap_valid,
                  lap_stamp, lap_duration, lap_peak, lap_total, laps_waiting, current_peak,
                  input ready);
  modport sink   (input valid, filtered_level, crossing_on, crossing_changed, lap_valid,
                  lap_stamp, lap_duration, lap_peak, lap_total, laps_waiting, current_peak,
                  output ready);
endinterface

>>> rtl/rssi_gate_crossing_lap_timer.sv
// Sequence: a sample word passes the window update, the 8-step divider of the window mean,
//   the crossing update and the finish step; pop, clear and ignored words pass only the
//   update and finish steps. A new word is accepted only back in idle, once the previous
//   word has reached the output register. A finished result waits in the output register.
// Reset: asynchronous; clears control, state and configuration registers; payload registers,
//   window and lap memories are not cleared: unwritten window entries are masked by the fill flag.
`timescale 1ns / 1ps

module rssi_gate_crossing_lap_timer import rgclt_pkg::*; #(
  parameter int unsigned WINDOW    = 8,
  parameter int unsigned LAP_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgclt_cmd_if.sink             cmd_i,
  rgclt_res_if.source           res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = LEVEL_W + $clog2(WINDOW);
  localparam int unsigned DW = SW + LEVEL_W;
  localparam int unsigned RW = $clog2(LAP_DEPTH);
  localparam int unsigned QSTEPS = LEVEL_W;

  localparam logic [PW-1:0] POS_LAST  = PW'(WINDOW - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(WINDOW);
  localparam logic [RW-1:0] RING_LAST = RW'(LAP_DEPTH - 1);
  localparam logic [RW:0]   RING_SIZE = (RW + 1)'(LAP_DEPTH);
  localparam logic [SW-1:0] SUM_MAX   = SW'(WINDOW * 255);
  localparam logic [2:0]    STEP_LAST = 3'(QSTEPS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  duration;
    logic [LEVEL_W-1:0] peak;
  } lap_entry_t;

  // Memories
  logic [LEVEL_W-1:0] win_mem [WINDOW];
  lap_entry_t         ring_mem [LAP_DEPTH];
  logic [LEVEL_W-1:0] win_rdata_q;
  lap_entry_t         ring_rdata_q;

  // Registers
  logic [2:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [LEVEL_W-1:0] smp_q, smp_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [LEVEL_W-1:0] quo_q, quo_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [PW-1:0]      wpos_q, wpos_d;
  logic               wfull_q, wfull_d;
  logic [LEVEL_W-1:0] last_q, last_d;
  logic [LEVEL_W-1:0] peak_q, peak_d;
  logic               incross_q, incross_d;
  logic [TIME_W-1:0]  begin_q, begin_d;
  logic [TIME_W-1:0]  prev_q, prev_d;
  logic [TOTAL_W-1:0] laps_q, laps_d;
  logic [RW-1:0]      wr_q, wr_d;
  logic [RW-1:0]      rd_q, rd_d;
  logic               chg_q, chg_d;
  logic               lapv_q, lapv_d;
  lap_entry_t         lap_q, lap_d;
  logic               out_valid_q, out_valid_d;
  res_word_t          out_q, out_d;
  logic [LEVEL_W-1:0] thr_q;
  logic               en_q;
  logic [MINMS_W-1:0] minms_q;

  // Memory controls
  logic       win_re, win_we, ring_re, ring_we;
  lap_entry_t ring_wdata;

  // Datapath helpers
  logic               accept;
  logic [LEVEL_W-1:0] old_level;
  logic [PW-1:0]      pos_next;
  logic               full_next;
  logic [DW-1:0]      dvs;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] peak_new;
  logic               active;
  logic [TIME_W-1:0]  span;
  logic [RW-1:0]      waiting;
  logic               load_out;

  assign accept      = cmd_i.valid & cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);

  // Window walk: the entry being replaced reads as zero until the window has filled
  assign old_level = wfull_q ? win_rdata_q : '0;
  assign pos_next  = (wpos_q == POS_LAST) ? '0 : wpos_q + 1'b1;
  assign full_next = wfull_q | (pos_next == '0);

  // Restoring divide: one quotient bit per cycle, most significant first
  assign dvs = DW'(cnt_q) << (STEP_LAST - step_q);

  // Crossing decisions on the finished mean
  assign level    = quo_q;
  assign peak_new = (level > peak_q) ? level : peak_q;
  assign active   = (level >= thr_q);
  assign span     = time_q - begin_q;

  // Queue fill, modulo the ring depth
  always_comb begin
    if (wr_q >= rd_q) begin
      waiting = wr_q - rd_q;
    end else begin
      waiting = RW'(RING_SIZE + (RW + 1)'(wr_q) - (RW + 1)'(rd_q));
    end
  end

  assign load_out = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    smp_d       = smp_q;
    time_d      = time_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    wpos_d      = wpos_q;
    wfull_d     = wfull_q;
    last_d      = last_q;
    peak_d      = peak_q;
    incross_d   = incross_q;
    begin_d     = begin_q;
    prev_d      = prev_q;
    laps_d      = laps_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    chg_d       = chg_q;
    lapv_d      = lapv_q;
    lap_d       = lap_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    win_re      = 1'b0;
    win_we      = 1'b0;
    ring_re     = 1'b0;
    ring_we     = 1'b0;
    ring_wdata  = '{stamp: time_q, duration: '0, peak: peak_new};

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_i.command;
          smp_d  = LEVEL_W'(cmd_i.adc_sample >> ADC_SHIFT);
          time_d = cmd_i.time_ms;
          if (cmd_i.command == CMD_SAMPLE && en_q) begin
            win_re  = 1'b1;
            state_d = ST_SUM;
          end else begin
            ring_re = 1'b1;
            state_d = ST_UPD;
          end
        end
      end
      ST_SUM: begin
        // Replace the oldest entry and keep the running sum
        win_we  = 1'b1;
        sum_d   = sum_q - SW'(old_level) + SW'(smp_q);
        wpos_d  = pos_next;
        wfull_d = full_next;
        cnt_d   = full_next ? CNT_FULL : CW'(pos_next);
        rem_d   = DW'(sum_d);
        quo_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_q >= dvs) begin
          rem_d = rem_q - dvs;
          quo_d = quo_q | (LEVEL_W'(1) << (STEP_LAST - step_q));
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        chg_d  = 1'b0;
        lapv_d = 1'b0;
        lap_d  = '0;
        if (cmd_q == CMD_SAMPLE && en_q) begin
          last_d = level;
          peak_d = peak_new;
          if (active != incross_q) begin
            incross_d = active;
            chg_d     = 1'b1;
            if (active) begin
              begin_d = time_q;
            end else if (span > TIME_W'(minms_q)) begin
              // Record a lap and restart the peak
              ring_wdata.duration = (prev_q != '0) ? time_q - prev_q : '0;
              ring_we = 1'b1;
              lap_d   = ring_wdata;
              lapv_d  = 1'b1;
              prev_d  = time_q;
              laps_d  = laps_q + 1'b1;
              wr_d    = (wr_q == RING_LAST) ? '0 : wr_q + 1'b1;
              peak_d  = '0;
            end
          end
        end else if (cmd_q == CMD_POP) begin
          if (rd_q != wr_q) begin
            lap_d  = ring_rdata_q;
            lapv_d = 1'b1;
            rd_d   = (rd_q == RING_LAST) ? '0 : rd_q + 1'b1;
          end
        end else if (cmd_q == CMD_CLEAR) begin
          laps_d    = '0;
          prev_d    = '0;
          peak_d    = '0;
          incross_d = 1'b0;
          wr_d      = '0;
          rd_d      = '0;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // Hand the word to the output register once it is free
        if (load_out) begin
          out_valid_d              = 1'b1;
          out_d.filtered_level     = last_q;
          out_d.crossing_on        = incross_q;
          out_d.crossing_changed   = chg_q;
          out_d.lap_valid          = lapv_q;
          out_d.lap_stamp          = lap_q.stamp;
          out_d.lap_duration       = lap_q.duration;
          out_d.lap_peak           = lap_q.peak;
          out_d.lap_total          = laps_q;
          out_d.laps_waiting       = WAIT_W'(waiting);
          out_d.current_peak       = peak_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Window memory
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[wpos_q] <= smp_q;
    end
    if (win_re) begin
      win_rdata_q <= win_mem[wpos_q];
    end
  end

  // Lap ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_q] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[rd_q];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      en_q    <= 1'b0;
      minms_q <= MIN_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q   <= cfg_data_i[LEVEL_W-1:0];
        CFG_ENABLE:    en_q    <= cfg_data_i[0];
        CFG_MIN_MS:    minms_q <= cfg_data_i[MINMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sum_q       <= '0;
      wpos_q      <= '0;
      wfull_q     <= 1'b0;
      last_q      <= '0;
      peak_q      <= '0;
      incross_q   <= 1'b0;
      begin_q     <= '0;
      prev_q      <= '0;
      laps_q      <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      wpos_q      <= wpos_d;
      wfull_q     <= wfull_d;
      last_q      <= last_d;
      peak_q      <= peak_d;
      incross_q   <= incross_d;
      begin_q     <= begin_d;
      prev_q      <= prev_d;
      laps_q      <= laps_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    smp_q  <= smp_d;
    time_q <= time_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    chg_q  <= chg_d;
    lapv_q <= lapv_d;
    lap_q  <= lap_d;
    out_q  <= out_d;
  end

  // Result channel
  assign res_o.valid            = out_valid_q;
  assign res_o.filtered_level   = out_q.filtered_level;
  assign res_o.crossing_on      = out_q.crossing_on;
  assign res_o.crossing_changed = out_q.crossing_changed;
  assign res_o.lap_valid        = out_q.lap_valid;
  assign res_o.lap_stamp        = out_q.lap_stamp;
  assign res_o.lap_duration     = out_q.lap_duration;
  assign res_o.lap_peak         = out_q.lap_peak;
  assign res_o.lap_total        = out_q.lap_total;
  assign res_o.laps_waiting     = out_q.laps_waiting;
  assign res_o.current_peak     = out_q.current_peak;

`ifndef SYNTHESIS
  // Window sum stays within a full window of maximum levels
  assert property (@(posedge clk_i) disable iff (!rst_ni) sum_q <= SUM_MAX)
    else $error("window sum out of range");

  // A word without a lap carries zero lap fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.lap_valid |->
      res_o.lap_stamp == '0 && res_o.lap_duration == '0 && res_o.lap_peak == '0)
    else $error("lap fields set without a lap");

  // A finished word reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_out |=> out_valid_q)
    else $error("finished word dropped");

  // The divide loop always hands over to the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && step_q == STEP_LAST |=> state_q == ST_UPD)
    else $error("divide did not complete");
`endif

endmodule
